// ===== hdl/csma_ca_transmit_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// CSMA/CA transmit sequencer assertion macros
// Concurrent assertion wrappers clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef CSMA_CA_TRANSMIT_SEQUENCER_UNIT_ASSERT_SVH
`define CSMA_CA_TRANSMIT_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CCTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CCTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CCTS_ASSERT(label, prop, msg)
`define CCTS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/ccts_pkg.sv =====
// ----------------------------------------------------------------------------
// CSMA/CA transmit sequencer package
// Field widths, register indexes, reset values, phase codes and the
// command and status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package ccts_pkg;

    localparam int SLOT_W     = 10;
    localparam int CW_INIT_W  = 11;
    localparam int CW_MAX_W   = 16;
    localparam int RND_W      = 16;
    localparam int STAGE_W    = 4;
    localparam int STAGE_CAP  = 15;
    localparam int PEND_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int COLL_W     = 12;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = $clog2(RND_W);

    localparam logic [CFG_IDX_W-1:0] CFG_DIFS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIFS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_INIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_MAX  = 3'd5;

    localparam logic [SLOT_W-1:0]    DIFS_RST    = 10'd2;
    localparam logic [SLOT_W-1:0]    SIFS_RST    = 10'd1;
    localparam logic [SLOT_W-1:0]    ACK_RST     = 10'd2;
    localparam logic [SLOT_W-1:0]    FRAME_RST   = 10'd100;
    localparam logic [CW_INIT_W-1:0] CW_INIT_RST = 11'd4;
    localparam logic [CW_MAX_W-1:0]  CW_MAX_RST  = 16'd1024;
    localparam logic [COLL_W-1:0]    COLL_RST    = 12'd103;

    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_COLLISION = 1'b1;

    typedef enum logic [PHASE_W-1:0] {
        PH_QUEUE     = 3'd0,
        PH_DIFS      = 3'd1,
        PH_BACKOFF   = 3'd2,
        PH_SENDING   = 3'd3,
        PH_SIFS      = 3'd4,
        PH_ACK       = 3'd5,
        PH_FREEZE    = 3'd6,
        PH_COLLISION = 3'd7
    } phase_t;

    typedef struct packed {
        logic               op;
        logic               frame_arrives;
        logic               medium_busy;
        logic [STAGE_W-1:0] collision_stage;
        logic [RND_W-1:0]   random_value;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] machine_state;
        logic [PEND_W-1:0]  frames_pending;
        logic [COUNT_W-1:0] ack_total;
        logic [COUNT_W-1:0] collision_total;
        logic               medium_released;
    } result_t;

    typedef struct packed {
        logic idle;
        logic step;
        logic coll;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic accepted;
        logic item_coll;
        logic step_wait;
        logic step_draw;
        logic draw_done;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/ccts_stream_if.sv =====
// ----------------------------------------------------------------------------
// CSMA/CA transmit sequencer stream interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface ccts_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ===== hdl/ccts_mod_unit.sv =====
// ----------------------------------------------------------------------------
// CSMA/CA transmit sequencer modulo unit
// Restoring remainder, one dividend bit per cycle; a zero divisor gives 0.
// ----------------------------------------------------------------------------
`include "csma_ca_transmit_sequencer_unit_assert.svh"

module ccts_mod_unit
    import ccts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [RND_W-1:0] divisor,
    output logic             done,
    output logic [RND_W-1:0] remainder
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RND_W-1:0] dvd_reg, dvd_next;
    logic [RND_W-1:0] div_reg, div_next;
    logic [RND_W-1:0] rem_reg, rem_next;
    logic [RND_W:0]   trial;
    logic [RND_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[RND_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RND_W - 1);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, div_reg}) ? diff[RND_W-1:0] : trial[RND_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = (div_reg == '0) ? '0 : rem_reg;

    `CCTS_ASSERT(a_no_restart, !(start && busy_reg), "modulo started while busy")
    `CCTS_ASSERT(a_rem_bound, !(done_reg && div_reg != '0) || rem_reg < div_reg, "remainder out of range")

endmodule

// ===== hdl/ccts_ctrl.sv =====
// ----------------------------------------------------------------------------
// CSMA/CA transmit sequencer controller
// Sequences acceptance, phase steps, backoff draws and result hand-off.
// ----------------------------------------------------------------------------
`include "csma_ca_transmit_sequencer_unit_assert.svh"

module ccts_ctrl
    import ccts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_ACK_DRAW,
        S_COLL,
        S_COLL_DRAW,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (status.accepted)
                begin
                    state_next = status.item_coll ? S_COLL : S_STEP;
                end
            end
            S_STEP:
            begin
                if (status.step_draw)
                begin
                    state_next = S_ACK_DRAW;
                end
                else if (status.step_wait)
                begin
                    state_next = S_FINISH;
                end
            end
            S_ACK_DRAW:
            begin
                if (status.draw_done)
                begin
                    state_next = S_STEP;
                end
            end
            S_COLL:
            begin
                state_next = S_COLL_DRAW;
            end
            S_COLL_DRAW:
            begin
                if (status.draw_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.idle   = (state_reg == S_IDLE);
    assign cmd.step   = (state_reg == S_STEP);
    assign cmd.coll   = (state_reg == S_COLL);
    assign cmd.finish = (state_reg == S_FINISH) && status.out_free;

    `CCTS_ASSERT(a_draw_in_wait, !status.draw_done || state_reg == S_ACK_DRAW || state_reg == S_COLL_DRAW, "draw finished outside a draw wait")
    `CCTS_ASSERT_NEXT(a_finish_to_idle, cmd.finish, state_reg == S_IDLE, "finish did not return to idle")

endmodule

// ===== hdl/ccts_datapath.sv =====
// ----------------------------------------------------------------------------
// CSMA/CA transmit sequencer datapath
// Configuration registers, phase and slot timers, counters, backoff draw
// and the registered result beat.
// ----------------------------------------------------------------------------
`include "csma_ca_transmit_sequencer_unit_assert.svh"

module ccts_datapath
    import ccts_pkg::*;
#(
    parameter int PENDING_MAX = 255,
    parameter int STAGE_LIMIT = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output status_t               status,
    ccts_stream_if.sink           item,
    ccts_stream_if.source         result
);

    localparam int PEND_LIMIT = (1 << PEND_W) - 1;
    localparam int PEND_INT   = (PENDING_MAX > PEND_LIMIT) ? PEND_LIMIT : PENDING_MAX;
    localparam logic [PEND_W-1:0] PEND_CAP = PEND_W'(PEND_INT);
    localparam int STAGE_TOP  = (STAGE_LIMIT > STAGE_CAP) ? STAGE_CAP : STAGE_LIMIT;
    localparam int PROD_W     = CW_INIT_W + STAGE_TOP;
    localparam int WIN_W      = (PROD_W > CW_MAX_W) ? PROD_W : CW_MAX_W;

    logic [SLOT_W-1:0]    difs_cfg_reg, sifs_cfg_reg, ack_cfg_reg, frame_cfg_reg;
    logic [CW_INIT_W-1:0] cw_init_reg;
    logic [CW_MAX_W-1:0]  cw_max_reg;

    phase_t               phase_reg, phase_next;
    logic [PEND_W-1:0]    pend_reg, pend_next;
    logic [SLOT_W-1:0]    difs_reg, difs_next;
    logic [SLOT_W-1:0]    sifs_reg, sifs_next;
    logic [SLOT_W-1:0]    ack_reg, ack_next;
    logic [SLOT_W-1:0]    send_reg, send_next;
    logic [RND_W-1:0]     backoff_reg, backoff_next;
    logic [COLL_W-1:0]    coll_left_reg, coll_left_next;
    logic [COUNT_W-1:0]   acks_reg, acks_next;
    logic [COUNT_W-1:0]   colls_reg, colls_next;
    logic                 rel_reg, rel_next;

    logic                 busy_reg, busy_next;
    logic [STAGE_W-1:0]   stage_reg, stage_next;
    logic [RND_W-1:0]     rnd_reg, rnd_next;

    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    logic                 accepted;
    logic                 step_wait;
    logic                 step_draw;
    logic [STAGE_W-1:0]   stage_c;
    logic [WIN_W-1:0]     prod;
    logic [WIN_W-1:0]     win_full;
    logic [RND_W-1:0]     coll_window;
    logic [RND_W-1:0]     ack_window;
    logic                 mod_start;
    logic                 mod_done;
    logic [RND_W-1:0]     mod_rem;

    assign accepted   = item.valid && cmd.idle;
    assign item.ready = cmd.idle;

    assign stage_c  = (stage_reg > STAGE_W'(STAGE_TOP)) ? STAGE_W'(STAGE_TOP) : stage_reg;
    assign prod     = WIN_W'(cw_init_reg) << stage_c;
    assign win_full = (prod == '0) ? '0 : prod - WIN_W'(1);
    assign coll_window = (win_full > WIN_W'(cw_max_reg)) ? cw_max_reg : win_full[RND_W-1:0];
    assign ack_window  = (cw_init_reg == '0) ? '0 : RND_W'(cw_init_reg - CW_INIT_W'(1));

    assign mod_start = (cmd.step && step_draw) || cmd.coll;

    ccts_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (rnd_reg),
        .divisor   (cmd.coll ? coll_window : ack_window),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        pend_next      = pend_reg;
        difs_next      = difs_reg;
        sifs_next      = sifs_reg;
        ack_next       = ack_reg;
        send_next      = send_reg;
        backoff_next   = backoff_reg;
        coll_left_next = coll_left_reg;
        acks_next      = acks_reg;
        colls_next     = colls_reg;
        rel_next       = rel_reg;
        busy_next      = busy_reg;
        stage_next     = stage_reg;
        rnd_next       = rnd_reg;
        step_wait      = 1'b0;
        step_draw      = 1'b0;

        if (accepted)
        begin
            busy_next  = item.payload.medium_busy;
            stage_next = item.payload.collision_stage;
            rnd_next   = item.payload.random_value;
            rel_next   = 1'b0;
            if (item.payload.op == OP_TICK && item.payload.frame_arrives && pend_reg < PEND_CAP)
            begin
                pend_next = pend_reg + PEND_W'(1);
            end
        end

        if (cmd.step)
        begin
            unique case (phase_reg)
                PH_QUEUE:
                begin
                    if (pend_reg != '0)
                    begin
                        phase_next = PH_DIFS;
                    end
                    else
                    begin
                        step_wait = 1'b1;
                    end
                end
                PH_DIFS:
                begin
                    if (difs_reg != '0)
                    begin
                        difs_next = difs_reg - SLOT_W'(1);
                        step_wait = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BACKOFF;
                    end
                end
                PH_BACKOFF:
                begin
                    if (busy_reg)
                    begin
                        phase_next = PH_FREEZE;
                    end
                    else if (backoff_reg != '0)
                    begin
                        backoff_next = backoff_reg - RND_W'(1);
                        step_wait    = 1'b1;
                    end
                    else
                    begin
                        send_next  = frame_cfg_reg;
                        phase_next = PH_SENDING;
                    end
                end
                PH_SENDING:
                begin
                    if (send_reg != '0)
                    begin
                        send_next = send_reg - SLOT_W'(1);
                        step_wait = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SIFS;
                    end
                end
                PH_SIFS:
                begin
                    if (sifs_reg != '0)
                    begin
                        sifs_next = sifs_reg - SLOT_W'(1);
                        step_wait = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ACK;
                    end
                end
                PH_ACK:
                begin
                    if (ack_reg != '0)
                    begin
                        ack_next  = ack_reg - SLOT_W'(1);
                        step_wait = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                        if (pend_reg != '0)
                        begin
                            pend_next = pend_reg - PEND_W'(1);
                        end
                        difs_next      = difs_cfg_reg;
                        sifs_next      = sifs_cfg_reg;
                        send_next      = frame_cfg_reg;
                        ack_next       = ack_cfg_reg;
                        coll_left_next = COLL_W'(sifs_cfg_reg) + COLL_W'(frame_cfg_reg)
                                       + COLL_W'(ack_cfg_reg);
                        acks_next      = acks_reg + COUNT_W'(1);
                        rel_next       = 1'b1;
                        phase_next     = PH_QUEUE;
                        step_draw      = 1'b1;
                    end
                end
                PH_FREEZE:
                begin
                    if (!busy_reg)
                    begin
                        phase_next = PH_BACKOFF;
                    end
                    else
                    begin
                        step_wait = 1'b1;
                    end
                end
                PH_COLLISION:
                begin
                    if (coll_left_reg != '0)
                    begin
                        coll_left_next = coll_left_reg - COLL_W'(1);
                        step_wait      = 1'b1;
                    end
                    else
                    begin
                        difs_next      = difs_cfg_reg;
                        sifs_next      = sifs_cfg_reg;
                        send_next      = frame_cfg_reg;
                        ack_next       = ack_cfg_reg;
                        coll_left_next = COLL_W'(sifs_cfg_reg) + COLL_W'(frame_cfg_reg)
                                       + COLL_W'(ack_cfg_reg);
                        phase_next     = PH_DIFS;
                    end
                end
                default:
                begin
                    phase_next = PH_QUEUE;
                end
            endcase
        end

        if (cmd.coll)
        begin
            phase_next = PH_COLLISION;
            colls_next = colls_reg + COUNT_W'(1);
        end

        if (mod_done)
        begin
            backoff_next = mod_rem;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (cmd.finish)
        begin
            res_valid_next           = 1'b1;
            res_next.machine_state   = phase_reg;
            res_next.frames_pending  = pend_reg;
            res_next.ack_total       = acks_reg;
            res_next.collision_total = colls_reg;
            res_next.medium_released = rel_reg;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            difs_cfg_reg  <= DIFS_RST;
            sifs_cfg_reg  <= SIFS_RST;
            ack_cfg_reg   <= ACK_RST;
            frame_cfg_reg <= FRAME_RST;
            cw_init_reg   <= CW_INIT_RST;
            cw_max_reg    <= CW_MAX_RST;
            phase_reg     <= PH_QUEUE;
            pend_reg      <= '0;
            difs_reg      <= DIFS_RST;
            sifs_reg      <= SIFS_RST;
            ack_reg       <= ACK_RST;
            send_reg      <= FRAME_RST;
            backoff_reg   <= '0;
            coll_left_reg <= COLL_RST;
            acks_reg      <= '0;
            colls_reg     <= '0;
            rel_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DIFS:    difs_cfg_reg  <= cfg_data[SLOT_W-1:0];
                    CFG_SIFS:    sifs_cfg_reg  <= cfg_data[SLOT_W-1:0];
                    CFG_ACK:     ack_cfg_reg   <= cfg_data[SLOT_W-1:0];
                    CFG_FRAME:   frame_cfg_reg <= cfg_data[SLOT_W-1:0];
                    CFG_CW_INIT: cw_init_reg   <= cfg_data[CW_INIT_W-1:0];
                    CFG_CW_MAX:  cw_max_reg    <= cfg_data[CW_MAX_W-1:0];
                    default:     ;
                endcase
            end
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            difs_reg      <= difs_next;
            sifs_reg      <= sifs_next;
            ack_reg       <= ack_next;
            send_reg      <= send_next;
            backoff_reg   <= backoff_next;
            coll_left_reg <= coll_left_next;
            acks_reg      <= acks_next;
            colls_reg     <= colls_next;
            rel_reg       <= rel_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        busy_reg  <= busy_next;
        stage_reg <= stage_next;
        rnd_reg   <= rnd_next;
        res_reg   <= res_next;
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

    assign status.accepted  = accepted;
    assign status.item_coll = (item.payload.op == OP_COLLISION);
    assign status.step_wait = step_wait;
    assign status.step_draw = step_draw;
    assign status.draw_done = mod_done;
    assign status.out_free  = !res_valid_reg || result.ready;

    `CCTS_ASSERT(a_pend_cap, pend_reg <= PEND_CAP, "pending count above cap")
    `CCTS_ASSERT_NEXT(a_ack_on_release, !(cmd.step && step_draw), acks_reg == $past(acks_reg), "ack count moved without release")

endmodule

// ===== hdl/csma_ca_transmit_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// CSMA/CA transmit sequencer
// Per-slot DCF transmit sequencer with binary exponential backoff.
// Slot tick: accept, then phase steps until the slot waits, then the result beat,
//   plus a backoff draw on each ACK completion.
// Collision notice: accept, then a backoff draw by the 16-step bit-serial modulo unit.
// One item at a time; next item accepted once the result is registered.
// Reset: phase queue, counters zero, timers and registers at defaults, no sweep.
// ----------------------------------------------------------------------------
module csma_ca_transmit_sequencer_unit
    import ccts_pkg::*;
#(
    parameter int PENDING_MAX = 255,
    parameter int STAGE_LIMIT = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ccts_stream_if.sink           item,
    ccts_stream_if.source         result
);

    cmd_t    cmd;
    status_t status;

    ccts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    ccts_datapath #(
        .PENDING_MAX (PENDING_MAX),
        .STAGE_LIMIT (STAGE_LIMIT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .result    (result)
    );

endmodule

// ===== tb/sv/csma_ca_transmit_sequencer_unit_test.sv =====
// ----------------------------------------------------------------------------
// CSMA/CA transmit sequencer unit test
// Drives slot ticks and collision notices into the sequencer and predicts the
// phase, pending count, ACK and collision totals and release flag of every
// status beat with a cycle-free model of the slot machine. Register settings
// cover the reset values, all-zero durations, the largest windows, a
// saturated queue drained in one slot and random small timings under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module csma_ca_transmit_sequencer_unit_test
    import ccts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PENDING_CAP   = 255;
    localparam int STAGE_CLAMP   = 10;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_SLOTS  = 330;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ccts_stream_if #(.payload_t(item_t))   slot_ch ();
    ccts_stream_if #(.payload_t(result_t)) report_ch ();

    csma_ca_transmit_sequencer_unit #(
        .PENDING_MAX (PENDING_CAP),
        .STAGE_LIMIT (STAGE_CLAMP)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (slot_ch),
        .result    (report_ch)
    );

    // register copies
    logic [SLOT_W-1:0]    difs_reg;
    logic [SLOT_W-1:0]    sifs_reg;
    logic [SLOT_W-1:0]    ack_reg;
    logic [SLOT_W-1:0]    frame_reg;
    logic [CW_INIT_W-1:0] cw_init_reg;
    logic [CW_MAX_W-1:0]  cw_max_reg;

    // sequencer state
    phase_t             seq_phase;
    logic [PEND_W-1:0]  pend_cnt;
    logic [SLOT_W-1:0]  difs_cnt;
    logic [SLOT_W-1:0]  sifs_cnt;
    logic [SLOT_W-1:0]  ack_cnt;
    logic [SLOT_W-1:0]  send_cnt;
    logic [RND_W-1:0]   backoff_cnt;
    logic [COLL_W-1:0]  coll_cnt;
    logic [COUNT_W-1:0] ack_count;
    logic [COUNT_W-1:0] coll_count;

    result_t expected_reports[$];
    int      error_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;

    function automatic void reload_slot_timers();
        difs_cnt = difs_reg;
        sifs_cnt = sifs_reg;
        send_cnt = frame_reg;
        ack_cnt  = ack_reg;
        coll_cnt = COLL_W'(32'(sifs_reg) + 32'(frame_reg) + 32'(ack_reg));
    endfunction

    function automatic void reset_sequencer();
        difs_reg    = DIFS_RST;
        sifs_reg    = SIFS_RST;
        ack_reg     = ACK_RST;
        frame_reg   = FRAME_RST;
        cw_init_reg = CW_INIT_RST;
        cw_max_reg  = CW_MAX_RST;
        seq_phase   = PH_QUEUE;
        pend_cnt    = '0;
        backoff_cnt = '0;
        ack_count   = '0;
        coll_count  = '0;
        reload_slot_timers();
    endfunction

    function automatic logic [RND_W-1:0] backoff_draw(logic [RND_W-1:0] rnd,
                                                      logic [31:0] window);
        return (window == 0) ? '0 : RND_W'(32'(rnd) % window);
    endfunction

    function automatic result_t predict_slot(item_t it);
        logic               busy;
        logic               released;
        logic               waiting;
        logic [STAGE_W-1:0] stg;
        logic [31:0]        prod;
        logic [31:0]        window;
        result_t            r;
        busy     = it.medium_busy;
        released = 1'b0;
        waiting  = 1'b0;
        if (it.op == OP_COLLISION) begin
            stg = it.collision_stage;
            if (stg > STAGE_CLAMP)
                stg = STAGE_W'(STAGE_CLAMP);
            prod   = (32'd1 << stg) * 32'(cw_init_reg);
            window = (prod == 0) ? 32'd0 : prod - 32'd1;
            if (window > 32'(cw_max_reg))
                window = 32'(cw_max_reg);
            backoff_cnt = backoff_draw(it.random_value, window);
            seq_phase   = PH_COLLISION;
            coll_count++;
        end
        else begin
            if (it.frame_arrives && pend_cnt < PENDING_CAP)
                pend_cnt++;
            while (!waiting) begin
                case (seq_phase)
                    PH_QUEUE:
                        if (pend_cnt != 0)
                            seq_phase = PH_DIFS;
                        else
                            waiting = 1'b1;
                    PH_DIFS:
                        if (difs_cnt != 0) begin
                            difs_cnt--;
                            waiting = 1'b1;
                        end
                        else
                            seq_phase = PH_BACKOFF;
                    PH_BACKOFF:
                        if (busy)
                            seq_phase = PH_FREEZE;
                        else if (backoff_cnt != 0) begin
                            backoff_cnt--;
                            waiting = 1'b1;
                        end
                        else begin
                            send_cnt  = frame_reg;
                            seq_phase = PH_SENDING;
                        end
                    PH_SENDING:
                        if (send_cnt != 0) begin
                            send_cnt--;
                            waiting = 1'b1;
                        end
                        else
                            seq_phase = PH_SIFS;
                    PH_SIFS:
                        if (sifs_cnt != 0) begin
                            sifs_cnt--;
                            waiting = 1'b1;
                        end
                        else
                            seq_phase = PH_ACK;
                    PH_ACK:
                        if (ack_cnt != 0) begin
                            ack_cnt--;
                            waiting = 1'b1;
                        end
                        else begin
                            busy = 1'b0;
                            if (pend_cnt != 0)
                                pend_cnt--;
                            reload_slot_timers();
                            backoff_cnt = backoff_draw(it.random_value,
                                (cw_init_reg == 0) ? 32'd0 : 32'(cw_init_reg) - 32'd1);
                            ack_count++;
                            released  = 1'b1;
                            seq_phase = PH_QUEUE;
                        end
                    PH_FREEZE:
                        if (!busy)
                            seq_phase = PH_BACKOFF;
                        else
                            waiting = 1'b1;
                    default:
                        if (coll_cnt != 0) begin
                            coll_cnt--;
                            waiting = 1'b1;
                        end
                        else begin
                            reload_slot_timers();
                            seq_phase = PH_DIFS;
                        end
                endcase
            end
        end
        r.machine_state   = seq_phase;
        r.frames_pending  = pend_cnt;
        r.ack_total       = ack_count;
        r.collision_total = coll_count;
        r.medium_released = released;
        return r;
    endfunction

    function automatic item_t make_slot(logic op, logic arrives, logic busy,
                                        logic [STAGE_W-1:0] stage,
                                        logic [RND_W-1:0] rnd);
        item_t it;
        it.op              = op;
        it.frame_arrives   = arrives;
        it.medium_busy     = busy;
        it.collision_stage = stage;
        it.random_value    = rnd;
        return it;
    endfunction

    function automatic item_t random_slot();
        return make_slot(($urandom_range(99) < 6) ? OP_COLLISION : OP_TICK,
                         $urandom_range(99) < 20, $urandom_range(99) < 25,
                         STAGE_W'($urandom_range(15)), RND_W'($urandom));
    endfunction

    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_slot(input item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            slot_ch.valid <= 1'b0;
            @(posedge clk);
        end
        slot_ch.valid   <= 1'b1;
        slot_ch.payload <= it;
        expected_reports.push_back(predict_slot(it));
        @(posedge clk);
        while (!slot_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_results_settled();
        slot_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_DIFS:    difs_reg    = data[SLOT_W-1:0];
            CFG_SIFS:    sifs_reg    = data[SLOT_W-1:0];
            CFG_ACK:     ack_reg     = data[SLOT_W-1:0];
            CFG_FRAME:   frame_reg   = data[SLOT_W-1:0];
            CFG_CW_INIT: cw_init_reg = data[CW_INIT_W-1:0];
            CFG_CW_MAX:  cw_max_reg  = data[CW_MAX_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] difs,
                                input logic [CFG_DATA_W-1:0] sifs,
                                input logic [CFG_DATA_W-1:0] ack,
                                input logic [CFG_DATA_W-1:0] frame,
                                input logic [CFG_DATA_W-1:0] cw_init,
                                input logic [CFG_DATA_W-1:0] cw_max);
        write_one(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_one(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        write_one(CFG_DIFS, difs);
        write_one(CFG_SIFS, sifs);
        write_one(CFG_ACK, ack);
        write_one(CFG_FRAME, frame);
        write_one(CFG_CW_INIT, cw_init);
        write_one(CFG_CW_MAX, cw_max);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_slot(make_slot(OP_TICK, 1'b0, 1'b0, 4'd0, 16'h0000));
        send_slot(make_slot(OP_TICK, 1'b1, 1'b0, 4'd0, 16'h0000));
        send_slot(make_slot(OP_TICK, 1'b0, 1'b1, 4'd15, 16'hFFFF));
        send_slot(make_slot(OP_TICK, 1'b1, 1'b1, 4'd7, 16'h5A5A));
        send_slot(make_slot(OP_TICK, 1'b0, 1'b1, 4'd8, 16'hA5A5));
        wait_results_settled();
    endtask

    task automatic test_zero_durations();
        // upper data bits fall outside the slot registers
        program_regs(16'hFC00, 16'hFC00, 16'hFC00, 16'hFC00, 16'd1, 16'd1);
        send_slot(make_slot(OP_TICK, 1'b1, 1'b0, 4'd0, RND_W'($urandom)));
        send_slot(make_slot(OP_TICK, 1'b1, 1'b1, 4'd0, RND_W'($urandom)));
        send_slot(make_slot(OP_TICK, 1'b0, 1'b1, 4'd0, RND_W'($urandom)));
        send_slot(make_slot(OP_TICK, 1'b0, 1'b1, 4'd0, RND_W'($urandom)));
        send_slot(make_slot(OP_TICK, 1'b1, 1'b1, 4'd0, RND_W'($urandom)));
        send_slot(make_slot(OP_TICK, 1'b0, 1'b0, 4'd0, RND_W'($urandom)));
        send_slot(make_slot(OP_COLLISION, 1'b1, 1'b1, 4'd0, RND_W'($urandom)));
        send_slot(make_slot(OP_TICK, 1'b0, 1'b0, 4'd0, RND_W'($urandom)));
        send_slot(make_slot(OP_COLLISION, 1'b0, 1'b0, 4'd15, 16'hFFFF));
        send_slot(make_slot(OP_TICK, 1'b0, 1'b0, 4'd0, RND_W'($urandom)));
        wait_results_settled();
    endtask

    task automatic test_extreme_windows();
        program_regs(16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'd1024, 16'd65535);
        send_slot(make_slot(OP_COLLISION, 1'b1, 1'b0, 4'd15, 16'hFFFF));
        send_slot(make_slot(OP_COLLISION, 1'b0, 1'b1, 4'd10, RND_W'($urandom)));
        send_slot(make_slot(OP_COLLISION, 1'b1, 1'b1, 4'd4, 16'hFFFF));
        wait_results_settled();
        program_regs(16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'd65535);
        send_slot(make_slot(OP_COLLISION, 1'b0, 1'b0, 4'd1, RND_W'($urandom)));
        send_slot(make_slot(OP_COLLISION, 1'b0, 1'b0, 4'd11, RND_W'($urandom)));
        send_slot(make_slot(OP_COLLISION, 1'b0, 1'b0, 4'd0, 16'h0000));
        wait_results_settled();
    endtask

    task automatic test_pending_saturation();
        program_regs(16'd0, 16'd0, 16'd0, 16'd260, 16'd1, 16'd1);
        send_slot(make_slot(OP_TICK, 1'b1, 1'b0, 4'd0, RND_W'($urandom)));
        repeat (257)
            send_slot(make_slot(OP_TICK, 1'b1, 1'($urandom_range(1)),
                                STAGE_W'($urandom_range(15)), RND_W'($urandom)));
        wait_results_settled();
        // full queue drains in a single slot once frames take no time
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
        repeat (4)
            send_slot(make_slot(OP_TICK, 1'b0, 1'b0, 4'd0, RND_W'($urandom)));
        wait_results_settled();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        program_regs(CFG_DATA_W'($urandom_range(3)), CFG_DATA_W'($urandom_range(2)),
                     CFG_DATA_W'($urandom_range(3)), CFG_DATA_W'($urandom_range(6)),
                     CFG_DATA_W'($urandom_range(8, 1)), CFG_DATA_W'($urandom_range(48, 1)));
        for (int i = 0; i < RANDOM_SLOTS; i++) begin
            // hold off until every status beat is back
            if (i == RANDOM_SLOTS / 2)
                wait_results_settled();
            send_slot(random_slot());
        end
        wait_results_settled();
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        report_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            report_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        result_t want;
        if (rst_n && report_ch.valid && report_ch.ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: status beat with nothing expected", $time);
                error_count++;
            end
            else begin
                want = expected_reports.pop_front();
                check_field("machine_state", 32'(want.machine_state),
                            32'(report_ch.payload.machine_state));
                check_field("frames_pending", 32'(want.frames_pending),
                            32'(report_ch.payload.frames_pending));
                check_field("ack_total", want.ack_total, report_ch.payload.ack_total);
                check_field("collision_total", want.collision_total,
                            report_ch.payload.collision_total);
                check_field("medium_released", 32'(want.medium_released),
                            32'(report_ch.payload.medium_released));
            end
        end
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        rst_n           <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= CFG_DIFS;
        cfg_data        <= '0;
        slot_ch.valid   <= 1'b0;
        slot_ch.payload <= '0;
        reset_sequencer();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_zero_durations();
        test_extreme_windows();
        test_pending_saturation();
        test_random_traffic(0, 0);
        test_random_traffic(74, 0);
        test_random_traffic(0, 74);
        test_random_traffic(6, 6);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ccts_pkg.sv
hdl/ccts_stream_if.sv
hdl/ccts_mod_unit.sv
hdl/ccts_ctrl.sv
hdl/ccts_datapath.sv
hdl/csma_ca_transmit_sequencer_unit.sv
tb/sv/csma_ca_transmit_sequencer_unit_test.sv
